>>> rtl/tpcm_pkg.sv
// Package for the touch point calibration map: widths, screen geometry,
// register indexes, control bit positions and rotation codes.
// No dependencies.
package tpcm_pkg;

	// Native panel geometry in pixels.
	localparam int NATIVE_WIDTH  = 320;
	localparam int NATIVE_HEIGHT = 480;

	// Field widths.
	localparam int ADC_W    = 12;
	localparam int COEF_W   = 32;
	localparam int SCREEN_W = 9;
	localparam int CTRL_W   = 3;
	localparam int IDX_W    = 3;

	// Fixed point format of the coefficients.
	localparam int FRAC_BITS = 16;
	localparam logic [ADC_W-1:0] ADC_FULL = '1;

	// Datapath widths: one product, the sum of two products and an offset,
	// and the rotated value with one more bit for the subtraction.
	localparam int PROD_W = COEF_W + ADC_W + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int ROT_W  = SUM_W + 1;

	// Largest native dimension and the width of a clamped Q value.
	localparam int NATIVE_MAX = (NATIVE_WIDTH > NATIVE_HEIGHT) ? NATIVE_WIDTH : NATIVE_HEIGHT;
	localparam int DIM_W      = $clog2(NATIVE_MAX);
	localparam int LAST_Q_W   = DIM_W + FRAC_BITS;
	localparam int RND_W      = LAST_Q_W + 1;

	// Last pixel column and row in Q format.
	localparam logic signed [ROT_W-1:0] WLAST_Q =
		ROT_W'(longint'(NATIVE_WIDTH - 1) <<< FRAC_BITS);
	localparam logic signed [ROT_W-1:0] HLAST_Q =
		ROT_W'(longint'(NATIVE_HEIGHT - 1) <<< FRAC_BITS);
	localparam logic [RND_W-1:0] HALF_Q = RND_W'(1) << (FRAC_BITS - 1);

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_X_GAIN_FROM_RAW_X = 3'd0,
		REG_X_GAIN_FROM_RAW_Y = 3'd1,
		REG_X_OFFSET          = 3'd2,
		REG_Y_GAIN_FROM_RAW_X = 3'd3,
		REG_Y_GAIN_FROM_RAW_Y = 3'd4,
		REG_Y_OFFSET          = 3'd5,
		REG_PRESSURE_THRESH   = 3'd6,
		REG_CONTROL           = 3'd7
	} reg_idx_t;

	// Control register layout.
	localparam int             CTRL_CAL_VALID_BIT = 2;
	localparam logic [CTRL_W-1:0] CTRL_ROT_MASK   = 3'h3;
	localparam logic [ADC_W-1:0]  THRESH_RESET    = 12'd300;

	// Rotation in quarter turns.
	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef logic signed [COEF_W-1:0] coef_t;

endpackage

>>> rtl/touch_point_calibration_map.sv
// Touch point calibration map: five-stage pipeline from raw panel readings
// to a rotated, clamped screen position. Depends on tpcm_pkg.
//
//  channel   handshake              payload
//  request   start / busy           sense_x_reading, sense_y_reading,
//                                   pressure_first, pressure_second
//  result    done (one cycle)       touched, pressed, screen_x, screen_y, pressure
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is taken in every cycle that start is high; busy is always low.
// One result per cycle is sustained. A request passes through the input
// register, the register after the four coefficient multipliers, the adder
// stage, the rotation stage and the output register. Reset clears the pipeline
// valid bits and restores the configuration registers. The receiver cannot
// stall, so nothing is held back.
module touch_point_calibration_map
	import tpcm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ADC_W-1:0]           sense_x_reading,
	input  logic [ADC_W-1:0]           sense_y_reading,
	input  logic [ADC_W-1:0]           pressure_first,
	input  logic [ADC_W-1:0]           pressure_second,
	output logic                       done,
	output logic                       touched,
	output logic                       pressed,
	output logic [SCREEN_W-1:0]        screen_x,
	output logic [SCREEN_W-1:0]        screen_y,
	output logic [ADC_W-1:0]           pressure,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [COEF_W-1:0]          cfg_data
);

	// Configuration registers.
	coef_t              coef_q [6];
	logic [ADC_W-1:0]   thresh_q;
	logic [CTRL_W-1:0]  ctrl_q;

	// Pipeline valid bits.
	logic v_s1, v_s2, v_s3, v_s4, done_q;

	// Stage 1: registered readings.
	logic [ADC_W-1:0] sx_rd_s1, sy_rd_s1, z1_s1, z2_s1;

	// Stage 2: products and pressure.
	logic signed [PROD_W-1:0] prod_s2 [4];
	logic [ADC_W-1:0]         pres_s2, pres_s3, pres_s4;
	logic                     pressed_s2, pressed_s3, pressed_s4;
	logic                     touched_s2, touched_s3, touched_s4;

	// Stage 3: native position in Q29.16.
	logic signed [SUM_W-1:0] nx_s3, ny_s3;

	// Stage 4: rotated position.
	logic signed [ROT_W-1:0] rx_s4, ry_s4;

	// Output registers.
	logic                touched_q, pressed_q;
	logic [SCREEN_W-1:0] screen_x_q, screen_y_q;
	logic [ADC_W-1:0]    pressure_q;

	// Combinational signals.
	logic [ADC_W-1:0]        raw_x, raw_y;
	logic signed [ADC_W+1:0] pres_raw;
	logic [ADC_W-1:0]        pres_clamped;
	logic                    pressed_c;
	logic signed [ROT_W-1:0] nx_e, ny_e, rot_x, rot_y;
	logic signed [ROT_W-1:0] last_x, last_y;
	logic [LAST_Q_W-1:0]     clamp_x, clamp_y;
	logic [RND_W-1:0]        round_x, round_y;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				coef_q[i] <= '0;
			end
			thresh_q <= THRESH_RESET;
			ctrl_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_GAIN_FROM_RAW_X: coef_q[0] <= cfg_data;
				REG_X_GAIN_FROM_RAW_Y: coef_q[1] <= cfg_data;
				REG_X_OFFSET:          coef_q[2] <= cfg_data;
				REG_Y_GAIN_FROM_RAW_X: coef_q[3] <= cfg_data;
				REG_Y_GAIN_FROM_RAW_Y: coef_q[4] <= cfg_data;
				REG_Y_OFFSET:          coef_q[5] <= cfg_data;
				REG_PRESSURE_THRESH:   thresh_q  <= cfg_data[ADC_W-1:0];
				REG_CONTROL:           ctrl_q    <= cfg_data[CTRL_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits travel with each request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	// Raw coordinates are the inverted readings; pressure is clamped to the ADC range.
	always_comb begin
		raw_x    = ADC_FULL - sx_rd_s1;
		raw_y    = ADC_FULL - sy_rd_s1;
		pres_raw = $signed({2'b00, ADC_FULL}) + $signed({2'b00, z1_s1})
			- $signed({2'b00, z2_s1});
		if (pres_raw < 0) begin
			pres_clamped = '0;
		end else if (pres_raw > $signed({2'b00, ADC_FULL})) begin
			pres_clamped = ADC_FULL;
		end else begin
			pres_clamped = pres_raw[ADC_W-1:0];
		end
		pressed_c = pres_clamped >= thresh_q;
	end

	// Rotation by quarter turns about the native screen.
	always_comb begin
		nx_e = ROT_W'(nx_s3);
		ny_e = ROT_W'(ny_s3);
		case (rot_t'(ctrl_q & CTRL_ROT_MASK))
			ROT_0: begin
				rot_x = nx_e;
				rot_y = ny_e;
			end
			ROT_90: begin
				rot_x = HLAST_Q - ny_e;
				rot_y = nx_e;
			end
			ROT_180: begin
				rot_x = WLAST_Q - nx_e;
				rot_y = HLAST_Q - ny_e;
			end
			ROT_270: begin
				rot_x = ny_e;
				rot_y = WLAST_Q - nx_e;
			end
			default: begin
				rot_x = nx_e;
				rot_y = ny_e;
			end
		endcase
	end

	// Clamp to the rotated screen, then round half-up to whole pixels.
	always_comb begin
		if (ctrl_q[0]) begin
			last_x = HLAST_Q;
			last_y = WLAST_Q;
		end else begin
			last_x = WLAST_Q;
			last_y = HLAST_Q;
		end
		if (rx_s4 < 0) begin
			clamp_x = '0;
		end else if (rx_s4 > last_x) begin
			clamp_x = last_x[LAST_Q_W-1:0];
		end else begin
			clamp_x = rx_s4[LAST_Q_W-1:0];
		end
		if (ry_s4 < 0) begin
			clamp_y = '0;
		end else if (ry_s4 > last_y) begin
			clamp_y = last_y[LAST_Q_W-1:0];
		end else begin
			clamp_y = ry_s4[LAST_Q_W-1:0];
		end
		round_x = {1'b0, clamp_x} + HALF_Q;
		round_y = {1'b0, clamp_y} + HALF_Q;
	end

	// Datapath registers; no reset needed on payload.
	always_ff @(posedge clk) begin
		// Stage 1: capture the readings.
		sx_rd_s1 <= sense_x_reading;
		sy_rd_s1 <= sense_y_reading;
		z1_s1    <= pressure_first;
		z2_s1    <= pressure_second;

		// Stage 2: one multiplier per gain coefficient, plus press detection.
		prod_s2[0] <= PROD_W'(coef_q[0]) * PROD_W'($signed({1'b0, raw_x}));
		prod_s2[1] <= PROD_W'(coef_q[1]) * PROD_W'($signed({1'b0, raw_y}));
		prod_s2[2] <= PROD_W'(coef_q[3]) * PROD_W'($signed({1'b0, raw_x}));
		prod_s2[3] <= PROD_W'(coef_q[4]) * PROD_W'($signed({1'b0, raw_y}));
		pres_s2    <= pres_clamped;
		pressed_s2 <= pressed_c;
		touched_s2 <= pressed_c && ctrl_q[CTRL_CAL_VALID_BIT];

		// Stage 3: affine sums.
		nx_s3      <= SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1]) + SUM_W'(coef_q[2]);
		ny_s3      <= SUM_W'(prod_s2[2]) + SUM_W'(prod_s2[3]) + SUM_W'(coef_q[5]);
		pres_s3    <= pres_s2;
		pressed_s3 <= pressed_s2;
		touched_s3 <= touched_s2;

		// Stage 4: rotation.
		rx_s4      <= rot_x;
		ry_s4      <= rot_y;
		pres_s4    <= pres_s3;
		pressed_s4 <= pressed_s3;
		touched_s4 <= touched_s3;

		// Output register: coordinates are zero unless touched.
		touched_q  <= touched_s4;
		pressed_q  <= pressed_s4;
		pressure_q <= pres_s4;
		screen_x_q <= touched_s4 ? SCREEN_W'(round_x[RND_W-1:FRAC_BITS]) : '0;
		screen_y_q <= touched_s4 ? SCREEN_W'(round_y[RND_W-1:FRAC_BITS]) : '0;
	end

	assign done     = done_q;
	assign touched  = touched_q;
	assign pressed  = pressed_q;
	assign screen_x = screen_x_q;
	assign screen_y = screen_y_q;
	assign pressure = pressure_q;

	// A result leaves only for a request that entered stage 1 and passed through v_s2, v_s3, v_s4 and done_q.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s1, 4))
		else $error("result without a matching request");

	// A position is only reported for a press.
	a_touch_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		done && touched |-> pressed)
		else $error("touched reported without a press");

	// Without a touch the coordinates are zero.
	a_idle_coords: assert property (@(posedge clk) disable iff (!arst_n)
		done && !touched |-> (screen_x == '0) && (screen_y == '0))
		else $error("coordinates not cleared when untouched");

endmodule

>>> verif/tb.sv
// Self-checking testbench for touch_point_calibration_map: drives panel reading requests,
// predicts each calibrated screen position and checks every result as it leaves the block.
// Depends on tpcm_pkg and the touch_point_calibration_map RTL.
module tb
	import tpcm_pkg::*;
();

	localparam int PIPE_LATENCY    = 5;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 58;

	// One expected result, laid out as the block reports it.
	typedef struct packed {
		logic                touched;
		logic                pressed;
		logic [SCREEN_W-1:0] screen_x;
		logic [SCREEN_W-1:0] screen_y;
		logic [ADC_W-1:0]    pressure;
	} touch_point_t;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                start           = 1'b0;
	logic [ADC_W-1:0]    sense_x_reading = '0;
	logic [ADC_W-1:0]    sense_y_reading = '0;
	logic [ADC_W-1:0]    pressure_first  = '0;
	logic [ADC_W-1:0]    pressure_second = '0;
	logic                cfg_valid       = 1'b0;
	logic [IDX_W-1:0]    cfg_index       = '0;
	logic [COEF_W-1:0]   cfg_data        = '0;
	logic                busy;
	logic                done;
	logic                touched;
	logic                pressed;
	logic [SCREEN_W-1:0] screen_x;
	logic [SCREEN_W-1:0] screen_y;
	logic [ADC_W-1:0]    pressure;
	logic                cfg_ready;

	// Shadow copy of the calibration registers as the block should hold them.
	coef_t               cal_coef [6];
	logic [ADC_W-1:0]    cal_thresh;
	logic [CTRL_W-1:0]   cal_ctrl;

	// Register words for the next configuration burst, indexed by register.
	logic [31:0]         plan_word [8];

	touch_point_t        pending_points [$];
	touch_point_t        head_point;
	int                  fault_count = 0;

	touch_point_calibration_map u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.sense_x_reading (sense_x_reading),
		.sense_y_reading (sense_y_reading),
		.pressure_first  (pressure_first),
		.pressure_second (pressure_second),
		.done            (done),
		.touched         (touched),
		.pressed         (pressed),
		.screen_x        (screen_x),
		.screen_y        (screen_y),
		.pressure        (pressure),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// Free-running clock, period 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Expected position for one set of readings under the current calibration.
	function automatic touch_point_t map_touch(input logic [ADC_W-1:0] sx_rd, sy_rd, z1, z2);
		longint       raw_x, raw_y, pr, nx, ny, qx, qy, wlast, hlast, span_x, span_y, half;
		touch_point_t r;
		raw_x = longint'(ADC_FULL) - longint'(sx_rd);
		raw_y = longint'(ADC_FULL) - longint'(sy_rd);
		pr    = longint'(ADC_FULL) - (longint'(z2) - longint'(z1));
		if (pr < 0)
			pr = 0;
		if (pr > longint'(ADC_FULL))
			pr = longint'(ADC_FULL);
		r.pressure = pr[ADC_W-1:0];
		r.pressed  = (pr >= longint'(cal_thresh));
		r.touched  = r.pressed && cal_ctrl[CTRL_CAL_VALID_BIT];
		r.screen_x = '0;
		r.screen_y = '0;
		if (r.touched) begin
			nx = longint'(cal_coef[REG_X_GAIN_FROM_RAW_X]) * raw_x
				+ longint'(cal_coef[REG_X_GAIN_FROM_RAW_Y]) * raw_y
				+ longint'(cal_coef[REG_X_OFFSET]);
			ny = longint'(cal_coef[REG_Y_GAIN_FROM_RAW_X]) * raw_x
				+ longint'(cal_coef[REG_Y_GAIN_FROM_RAW_Y]) * raw_y
				+ longint'(cal_coef[REG_Y_OFFSET]);
			wlast = longint'(NATIVE_WIDTH - 1) <<< FRAC_BITS;
			hlast = longint'(NATIVE_HEIGHT - 1) <<< FRAC_BITS;
			half  = longint'(1) <<< (FRAC_BITS - 1);
			// Quarter turns; odd turns swap the screen dimensions.
			case (rot_t'(cal_ctrl[1:0]))
				ROT_0: begin
					qx = nx;
					qy = ny;
				end
				ROT_90: begin
					qx = hlast - ny;
					qy = nx;
				end
				ROT_180: begin
					qx = wlast - nx;
					qy = hlast - ny;
				end
				default: begin
					qx = ny;
					qy = wlast - nx;
				end
			endcase
			if (cal_ctrl[0]) begin
				span_x = hlast;
				span_y = wlast;
			end else begin
				span_x = wlast;
				span_y = hlast;
			end
			// Clamp to the screen before rounding half-up.
			if (qx < 0)
				qx = 0;
			if (qx > span_x)
				qx = span_x;
			if (qy < 0)
				qy = 0;
			if (qy > span_y)
				qy = span_y;
			qx = (qx + half) >>> FRAC_BITS;
			qy = (qy + half) >>> FRAC_BITS;
			r.screen_x = qx[SCREEN_W-1:0];
			r.screen_y = qy[SCREEN_W-1:0];
		end
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	function automatic logic [31:0] control_word(input bit valid, input rot_t rot);
		return (32'(valid) << CTRL_CAL_VALID_BIT) | 32'(rot);
	endfunction

	task automatic idle_for(input int unsigned cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Send one request, record its expected result once taken, then idle.
	task automatic send_reading(input logic [ADC_W-1:0] sx, sy, z1, z2,
			input int unsigned gap_after);
		start           <= 1'b1;
		sense_x_reading <= sx;
		sense_y_reading <= sy;
		pressure_first  <= z1;
		pressure_second <= z2;
		do @(posedge clk); while (busy);
		pending_points.push_back(map_touch(sx, sy, z1, z2));
		idle_for(gap_after);
	endtask

	// Stop requesting and wait until every outstanding result has come back.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	// Write one register; valid stays high so a following write can go straight on.
	task automatic write_register(input reg_idx_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PRESSURE_THRESH: cal_thresh = data[ADC_W-1:0];
			REG_CONTROL:         cal_ctrl   = data[CTRL_W-1:0];
			default:             cal_coef[idx] = data;
		endcase
	endtask

	// Write all eight registers from plan_word once the block is idle.
	task automatic apply_plan();
		int unsigned gap;
		wait_idle();
		for (int i = 0; i < 8; i++) begin
			if (i > 0) begin
				gap = pick_gap();
				if (gap > 0) begin
					cfg_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			write_register(reg_idx_t'(i), plan_word[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [31:0] xx, xy, xo, yx, yy, yo, thr_word, ctl_word);
		plan_word[REG_X_GAIN_FROM_RAW_X] = xx;
		plan_word[REG_X_GAIN_FROM_RAW_Y] = xy;
		plan_word[REG_X_OFFSET]          = xo;
		plan_word[REG_Y_GAIN_FROM_RAW_X] = yx;
		plan_word[REG_Y_GAIN_FROM_RAW_Y] = yy;
		plan_word[REG_Y_OFFSET]          = yo;
		plan_word[REG_PRESSURE_THRESH]   = thr_word;
		plan_word[REG_CONTROL]           = ctl_word;
		apply_plan();
	endtask

	// Reset values: no calibration, so only pressure and press are reported.
	task automatic test_reset_state();
		send_reading(12'd0, 12'd0, 12'd0, 12'd0, pick_gap());
		send_reading(12'd4095, 12'd4095, 12'd0, 12'd4095, pick_gap());
		send_reading(12'hAAA, 12'h555, 12'd4095, 12'd0, pick_gap());
		send_reading(12'd100, 12'd200, 12'd0, 12'd3796, pick_gap());
	endtask

	// Press threshold edges, ignored upper register bits and an invalid calibration.
	task automatic test_press_threshold();
		configure(32'd5120, 0, 0, 0, 32'd7680, 0, 32'd300, control_word(1'b1, ROT_0));
		send_reading(12'd1000, 12'd1000, 12'd0, 12'd3795, pick_gap());
		send_reading(12'd1000, 12'd1000, 12'd0, 12'd3796, pick_gap());
		configure(32'd5120, 0, 0, 0, 32'd7680, 0, 32'hFFFF_F000,
			control_word(1'b1, ROT_0));
		send_reading(12'd2000, 12'd2000, 12'd0, 12'd4095, pick_gap());
		configure(32'd5120, 0, 0, 0, 32'd7680, 0, 32'hFFFF_FFFF,
			32'hABCD_E000 | control_word(1'b1, ROT_0));
		send_reading(12'd3000, 12'd500, 12'd7, 12'd7, pick_gap());
		send_reading(12'd3000, 12'd500, 12'd0, 12'd1, pick_gap());
		configure(32'd5120, 0, 0, 0, 32'd7680, 0, 32'd0, control_word(1'b0, ROT_90));
		send_reading(12'd1000, 12'd1000, 12'd5, 12'd5, pick_gap());
	endtask

	// Each quarter turn with the panel corners, which map to the screen corners.
	task automatic test_rotations();
		for (int r = 0; r < 4; r++) begin
			configure(32'd5120, 0, 0, 0, 32'd7680, 0, 32'd0, control_word(1'b1, rot_t'(r)));
			send_reading(12'd0, 12'd0, 12'd2000, 12'd2000, pick_gap());
			send_reading(12'd4095, 12'd4095, 12'd2000, 12'd2000, pick_gap());
		end
	endtask

	// Rounding at one half, clamping past the last pixel and below zero.
	task automatic test_screen_edges();
		configure(0, 0, 32'd32768, 0, 0, 32'd32767, 32'd0, control_word(1'b1, ROT_0));
		send_reading(12'd1234, 12'd3210, 12'd0, 12'd0, pick_gap());
		configure(0, 0, (319 << 16) + 49152, 0, 0, -65536, 32'd0, control_word(1'b1, ROT_0));
		send_reading(12'd1234, 12'd3210, 12'd0, 12'd0, pick_gap());
		configure(0, 0, -1, 0, 0, (479 << 16) + 32768, 32'd0, control_word(1'b1, ROT_270));
		send_reading(12'd1234, 12'd3210, 12'd0, 12'd0, pick_gap());
	endtask

	// Largest and smallest coefficients, so the sums reach their widest.
	task automatic test_coef_extremes();
		configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, control_word(1'b1, ROT_180));
		send_reading(12'd0, 12'd0, 12'd0, 12'd0, pick_gap());
		configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'd0, control_word(1'b1, ROT_90));
		send_reading(12'd0, 12'd0, 12'd0, 12'd0, pick_gap());
	endtask

	// A plausible panel fit: gains near full scale, either sense, small cross terms.
	task automatic fill_realistic_plan();
		int g, jit;
		g   = int'($urandom_range(4000, 9000));
		jit = int'($urandom_range(0, 40 << 16)) - (20 << 16);
		if ($urandom_range(0, 1)) begin
			plan_word[REG_X_GAIN_FROM_RAW_X] = -g;
			plan_word[REG_X_OFFSET]          = (330 << 16) + jit;
		end else begin
			plan_word[REG_X_GAIN_FROM_RAW_X] = g;
			plan_word[REG_X_OFFSET]          = jit - (10 << 16);
		end
		plan_word[REG_X_GAIN_FROM_RAW_Y] = int'($urandom_range(0, 600)) - 300;
		g   = int'($urandom_range(6000, 12000));
		jit = int'($urandom_range(0, 40 << 16)) - (20 << 16);
		if ($urandom_range(0, 1)) begin
			plan_word[REG_Y_GAIN_FROM_RAW_Y] = -g;
			plan_word[REG_Y_OFFSET]          = (490 << 16) + jit;
		end else begin
			plan_word[REG_Y_GAIN_FROM_RAW_Y] = g;
			plan_word[REG_Y_OFFSET]          = jit - (10 << 16);
		end
		plan_word[REG_Y_GAIN_FROM_RAW_X] = int'($urandom_range(0, 600)) - 300;
	endtask

	// Random readings, mostly pressed, some on the threshold, some anything at all.
	task automatic send_random_reading(input bit burst);
		int r, d, thr, z1, z2;
		thr = int'(cal_thresh);
		r   = int'($urandom_range(0, 99));
		if (r < 70)
			d = int'($urandom_range(0, 8190 - thr)) - 4095;
		else if (r < 85)
			d = 4095 - thr + int'($urandom_range(0, 2)) - 1;
		else
			d = int'($urandom_range(0, 8190)) - 4095;
		if (d > 4095)
			d = 4095;
		if (d < 0) begin
			z1 = int'($urandom_range(-d, 4095));
		end else begin
			z1 = int'($urandom_range(0, 4095 - d));
		end
		z2 = z1 + d;
		send_reading(ADC_W'($urandom_range(0, 4095)), ADC_W'($urandom_range(0, 4095)),
			ADC_W'(z1), ADC_W'(z2), burst ? 0 : pick_gap());
	endtask

	// Phases of random traffic, each under a freshly written calibration.
	task automatic test_random_traffic();
		bit burst;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 1) begin
				for (int i = 0; i < 6; i++)
					plan_word[i] = $urandom();
			end else if (p == 2) begin
				for (int i = 0; i < 6; i++) begin
					case ($urandom_range(0, 3))
						0:       plan_word[i] = 32'h7FFF_FFFF;
						1:       plan_word[i] = 32'h8000_0000;
						2:       plan_word[i] = 32'h0000_0000;
						default: plan_word[i] = $urandom();
					endcase
				end
			end else begin
				fill_realistic_plan();
			end
			plan_word[REG_PRESSURE_THRESH] = $urandom() & 32'hFFFF_F000;
			if (p == 3)
				plan_word[REG_PRESSURE_THRESH][ADC_W-1:0] = '0;
			else if (p == 4)
				plan_word[REG_PRESSURE_THRESH][ADC_W-1:0] = '1;
			else if ($urandom_range(0, 3) == 0)
				plan_word[REG_PRESSURE_THRESH][ADC_W-1:0] = ADC_W'($urandom_range(0, 4095));
			else
				plan_word[REG_PRESSURE_THRESH][ADC_W-1:0] = ADC_W'($urandom_range(50, 800));
			plan_word[REG_CONTROL] = ($urandom() & 32'hFFFF_FFF8)
				| control_word($urandom_range(0, 9) != 0, rot_t'(p % 4));
			apply_plan();
			burst = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_random_reading(burst);
		end
	endtask

	// Each result is checked against the oldest outstanding request.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_points.size() == 0) begin
				$error("tb: result with no request outstanding");
				fault_count++;
			end else begin
				head_point = pending_points.pop_front();
				if (touched !== head_point.touched) begin
					$error("tb: touched expected %0d actual %0d", head_point.touched, touched);
					fault_count++;
				end
				if (pressed !== head_point.pressed) begin
					$error("tb: pressed expected %0d actual %0d", head_point.pressed, pressed);
					fault_count++;
				end
				if (screen_x !== head_point.screen_x) begin
					$error("tb: screen_x expected %0d actual %0d",
						head_point.screen_x, screen_x);
					fault_count++;
				end
				if (screen_y !== head_point.screen_y) begin
					$error("tb: screen_y expected %0d actual %0d",
						head_point.screen_y, screen_y);
					fault_count++;
				end
				if (pressure !== head_point.pressure) begin
					$error("tb: pressure expected %0d actual %0d",
						head_point.pressure, pressure);
					fault_count++;
				end
			end
		end
	end

	// Test sequence.
	initial begin
		for (int i = 0; i < 6; i++)
			cal_coef[i] = '0;
		cal_thresh = THRESH_RESET;
		cal_ctrl   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_press_threshold();
		test_rotations();
		test_screen_edges();
		test_coef_extremes();
		test_random_traffic();
		wait_idle();
		repeat (PIPE_LATENCY + 3) @(posedge clk);
		if (fault_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#10_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
